@@ rtl/core/b2da_pkg.sv @@
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and command type for the binary to decimal ASCII core.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_DIGITS = 10;

    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture a new value, clear the BCD register
        logic shift;  // run two double-dabble steps (two input bits)
        logic emit;   // load the output character register
    } b2da_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/b2da_datapath.sv @@
// ----------------------------------------------------------------------------
// b2da_datapath
// Binary shift register, BCD register with double-dabble steps, leading
// digit search and output character register.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_datapath
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS,
    parameter int IDX_W      = $clog2(MAX_DIGITS)
)
(
    input  wire logic                  clk,
    input  wire b2da_cmd_t             cmd,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic [IDX_W-1:0]      emit_idx,
    output logic [IDX_W-1:0]           msd_idx,
    output logic [CHAR_W-1:0]          digit_char
);

    // pad to an even width so that two bits enter per step
    localparam int SHIFT_BITS = ((VALUE_BITS + 1) / 2) * 2;
    localparam int BCD_W      = 4 * MAX_DIGITS;

    logic [SHIFT_BITS-1:0] bin_reg;
    logic [SHIFT_BITS-1:0] bin_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [CHAR_W-1:0]     char_reg;
    logic [BCD_W:0]        step1;
    logic [BCD_W:0]        step2;

    // one double-dabble step: adjust digits, shift in a bit, return carry out
    function automatic logic [BCD_W:0] dabble(input logic [BCD_W-1:0] bcd,
                                              input logic bit_in);
        logic [BCD_W-1:0] adj;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd[4*i +: 4];
        end
        return {adj, bit_in};
    endfunction

    always_comb
    begin
        step1    = dabble(bcd_reg, bin_reg[SHIFT_BITS-1]);
        step2    = dabble(step1[BCD_W-1:0], bin_reg[SHIFT_BITS-2]);
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        ovf_next = ovf_reg;
        if (cmd.load)
        begin
            bin_next = SHIFT_BITS'(value);
            bcd_next = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.shift)
        begin
            bin_next = {bin_reg[SHIFT_BITS-3:0], 2'b00};
            bcd_next = step2[BCD_W-1:0];
            // any carry out of the top digit means the value does not fit
            ovf_next = ovf_reg | step1[BCD_W] | step2[BCD_W];
        end
    end

    // highest nonzero digit; all digits when the value overflowed
    always_comb
    begin
        msd_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                msd_idx = IDX_W'(i);
        end
        if (ovf_reg)
            msd_idx = IDX_W'(MAX_DIGITS - 1);
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        ovf_reg <= ovf_next;
        if (cmd.emit)
            char_reg <= ASCII_ZERO + {2'b00, bcd_reg[4*emit_idx +: 4]};
    end

    assign digit_char = char_reg;

endmodule

`default_nettype wire

@@ rtl/core/b2da_ctrl.sv @@
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: accepts an item, runs the conversion steps, sizes the number
// and hands out the digits through the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_ctrl
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS,
    parameter int IDX_W      = $clog2(MAX_DIGITS)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             value_valid,
    output logic                  value_ready,
    output logic                  digit_valid,
    input  wire logic             digit_ready,
    output logic                  last_digit,
    output b2da_cmd_t             cmd,
    output logic [IDX_W-1:0]      emit_idx,
    input  wire logic [IDX_W-1:0] msd_idx
);

    localparam int STEPS = ((VALUE_BITS + 1) / 2);
    localparam int CNT_W = $clog2(STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIZE,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             valid_reg;
    logic             last_reg;
    logic             slot_free;

    assign slot_free = !valid_reg || digit_ready;

    always_comb
    begin
        cmd       = '0;
        cmd.load  = (state_reg == ST_IDLE) && value_valid;
        cmd.shift = (state_reg == ST_CONVERT);
        cmd.emit  = (state_reg == ST_EMIT) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            // load a new digit when the slot frees, else drop the taken one
            if (cmd.emit)
                valid_reg <= 1'b1;
            else if (digit_ready)
                valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (value_valid)
                    begin
                        cnt_reg   <= CNT_W'(STEPS - 1);
                        state_reg <= ST_CONVERT;
                    end
                end
                ST_CONVERT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= ST_SIZE;
                end
                ST_SIZE:
                begin
                    idx_reg   <= msd_idx;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        last_reg  <= (idx_reg == '0);
                        idx_reg   <= idx_reg - 1'b1;
                        if (idx_reg == '0)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign value_ready = (state_reg == ST_IDLE);
    assign digit_valid = valid_reg;
    assign last_digit  = last_reg;
    assign emit_idx    = idx_reg;

    // the final digit of an item flags last and returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && idx_reg == '0)
        |=> (state_reg == ST_IDLE && last_reg && valid_reg))
        else $error("final digit did not end the item");

    // a digit that is not taken must not be replaced
    a_hold_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !digit_ready) |=> (valid_reg && $stable(last_reg)))
        else $error("pending digit changed while stalled");

    // the last conversion step always passes on to sizing
    a_convert_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONVERT && cnt_reg == '0) |=> (state_reg == ST_SIZE))
        else $error("conversion did not finish on the last step");

    // only the last digit of an item may leave the sequencer idle-bound
    a_last_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && idx_reg != '0)
        |=> (state_reg == ST_EMIT && !last_reg))
        else $error("digit flagged last too early");

endmodule

`default_nettype wire

@@ rtl/core/binary_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts an unsigned binary value to ASCII decimal digits, MSD first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel value/value_valid/value_ready takes one number per item.
//   Output channel digit_char/last_digit/digit_valid/digit_ready gives one
//   ASCII digit per item, most significant first, no leading zeros; zero
//   gives a single '0'. last_digit marks the least significant digit. When
//   the value needs more than MAX_DIGITS digits, the low MAX_DIGITS decimal
//   digits are given, leading zeros included.
// Timing:
//   The number goes through a double-dabble shifter, two bits per cycle;
//   then the leading digit is found, and the digits are given one per
//   cycle while the receiver is ready. value_ready is high only while no
//   item is being converted or emitted; the last digit may still wait in
//   the output register while the next item is taken.
// Reset:
//   rst_n clears the sequencer and the output valid; nothing else is kept.
//   A stalled receiver holds the current digit and pauses the emission.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_core
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [VALUE_BITS-1:0] value,
    input  wire logic                  value_valid,
    output logic                       value_ready,
    output logic [CHAR_W-1:0]          digit_char,
    output logic                       last_digit,
    output logic                       digit_valid,
    input  wire logic                  digit_ready
);

    localparam int IDX_W = $clog2(MAX_DIGITS);

    b2da_cmd_t        cmd;
    logic [IDX_W-1:0] emit_idx;
    logic [IDX_W-1:0] msd_idx;

    b2da_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .last_digit  (last_digit),
        .cmd         (cmd),
        .emit_idx    (emit_idx),
        .msd_idx     (msd_idx)
    );

    b2da_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .value      (value),
        .emit_idx   (emit_idx),
        .msd_idx    (msd_idx),
        .digit_char (digit_char)
    );

endmodule

`default_nettype wire
